// ----- hdl/cfd_pkg.sv -----
package cfd_pkg;

    localparam logic [7:0]  HEAD_BYTE    = 8'hAA;
    localparam logic [7:0]  TAIL_BYTE    = 8'h55;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  CRC_LAG      = 8'd3;
    localparam logic [7:0]  MAX_STORED_RESET = 8'd100;
    localparam logic [15:0] ERR_SAT      = 16'hFFFF;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_START    = 3'd1,
        EV_GOOD     = 3'd2,
        EV_CRC_ERR  = 3'd3,
        EV_SHORT    = 3'd4,
        EV_OVERFLOW = 3'd5
    } t_frame_event;

    typedef struct packed {
        logic         byte_valid;
        logic [7:0]   byte_value;
        logic [7:0]   byte_index;
        t_frame_event frame_event;
        logic [7:0]   payload_length;
        logic [15:0]  command_word;
        logic [15:0]  computed_crc;
        logic [15:0]  error_total;
    } t_result;

    // one byte of reflected modbus crc
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/cfd_if.sv -----
interface cfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_stored_bytes;
    modport source (output valid, output max_stored_bytes, input ready);
    modport sink (input valid, input max_stored_bytes, output ready);
endinterface

interface cfd_res_if;
    logic                  valid;
    logic                  ready;
    logic                  byte_valid;
    logic [7:0]            byte_value;
    logic [7:0]            byte_index;
    cfd_pkg::t_frame_event frame_event;
    logic [7:0]            payload_length;
    logic [15:0]           command_word;
    logic [15:0]           computed_crc;
    logic [15:0]           error_total;
    modport source (
        output valid, output byte_valid, output byte_value, output byte_index,
        output frame_event, output payload_length, output command_word,
        output computed_crc, output error_total, input ready
    );
    modport sink (
        input valid, input byte_valid, input byte_value, input byte_index,
        input frame_event, input payload_length, input command_word,
        input computed_crc, input error_total, output ready
    );
endinterface

// ----- hdl/crc16_checked_frame_deframer_unit.sv -----
// an accepted byte waits in the input register, then steps the core into the result register
// throughput: one byte per cycle, set by the one-byte crc fold and frame
// compares between the input register and the result register
// a stalled result holds the input register, which then holds off the input side
// reset: synchronous active-low i_rst_n clears frame state, crc to 0xFFFF,
// command word and error count, and sets max_stored_bytes to 100
module crc16_checked_frame_deframer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfd_rx_if.sink    i_rx,
    cfd_cfg_if.sink   i_cfg,
    cfd_res_if.source o_res
);
    import cfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_max_stored;

    logic       advance;
    t_result    core_res;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    cfd_frame_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .i_max_stored (r_max_stored),
        .o_result     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_stored <= MAX_STORED_RESET;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_max_stored <= i_cfg.max_stored_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.byte_valid     = r_out.byte_valid;
    assign o_res.byte_value     = r_out.byte_value;
    assign o_res.byte_index     = r_out.byte_index;
    assign o_res.frame_event    = r_out.frame_event;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.command_word   = r_out.command_word;
    assign o_res.computed_crc   = r_out.computed_crc;
    assign o_res.error_total    = r_out.error_total;

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not filled after step");

    a_held_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && (r_in_byte == $past(r_in_byte)))
        else $error("pending byte lost while stalled");

    a_no_step_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !advance)
        else $error("stepped while result stalled");

endmodule

// ----- hdl/cfd_frame_core.sv -----
module cfd_frame_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_max_stored,
    output cfd_pkg::t_result o_result
);
    import cfd_pkg::*;

    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_prev, n_prev;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_recent [3];
    logic [7:0]  n_recent [3];
    logic [15:0] r_cmd, n_cmd;
    logic [15:0] r_err, n_err;

    logic        is_head;
    logic        is_tail;
    logic        err_inc;
    t_result     res;

    assign is_head = (i_byte == HEAD_BYTE) && (r_prev == HEAD_BYTE);
    assign is_tail = r_in_frame && (i_byte == TAIL_BYTE) && (r_prev == TAIL_BYTE);

    always_comb begin
        n_in_frame = r_in_frame;
        n_prev     = i_byte;
        n_count    = r_count;
        n_crc      = r_crc;
        n_recent   = r_recent;
        n_cmd      = r_cmd;
        err_inc    = 1'b0;
        res        = '0;
        res.frame_event = EV_NONE;

        priority if (is_head) begin
            n_count    = '0;
            n_crc      = CRC_INIT;
            n_in_frame = 1'b1;
            res.frame_event = EV_START;
        end else if (is_tail) begin
            n_in_frame = 1'b0;
            if (r_count < CRC_LAG) begin
                err_inc = 1'b1;
                res.frame_event = EV_SHORT;
            end else begin
                res.payload_length = r_count - CRC_LAG;
                res.computed_crc   = r_crc;
                if ({r_recent[1], r_recent[2]} == r_crc) begin
                    res.frame_event = EV_GOOD;
                end else begin
                    err_inc = 1'b1;
                    res.frame_event = EV_CRC_ERR;
                end
            end
        end else if (r_in_frame) begin
            if (r_count >= CRC_LAG) begin
                n_crc = crc_fold(r_crc, r_recent[2]);
            end
            n_recent[2] = r_recent[1];
            n_recent[1] = r_recent[0];
            n_recent[0] = i_byte;
            if (r_count == 8'd0) begin
                n_cmd = {i_byte, r_cmd[7:0]};
            end else if (r_count == 8'd1) begin
                n_cmd = {r_cmd[15:8], i_byte};
            end
            res.byte_valid = 1'b1;
            res.byte_value = i_byte;
            res.byte_index = r_count;
            n_count = r_count + 8'd1;
            if (n_count >= i_max_stored) begin
                n_in_frame = 1'b0;
                err_inc    = 1'b1;
                res.frame_event = EV_OVERFLOW;
            end
        end else begin
            n_in_frame = 1'b0;
        end

        n_err = (err_inc && (r_err != ERR_SAT)) ? r_err + 16'd1 : r_err;
        res.command_word = n_cmd;
        res.error_total  = n_err;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_prev     <= '0;
            r_count    <= '0;
            r_crc      <= CRC_INIT;
            r_recent   <= '{default: '0};
            r_cmd      <= '0;
            r_err      <= '0;
        end else if (i_step) begin
            r_in_frame <= n_in_frame;
            r_prev     <= n_prev;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_recent   <= n_recent;
            r_cmd      <= n_cmd;
            r_err      <= n_err;
        end
    end

    a_head_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && is_head |=> r_in_frame && (r_count == 8'd0) && (r_crc == CRC_INIT))
        else $error("head pair did not open a frame");

    a_no_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !r_in_frame && !is_head |=> !r_in_frame)
        else $error("frame opened without head pair");

    a_overflow_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (res.frame_event == EV_OVERFLOW) |=> !r_in_frame && (r_err != 16'd0))
        else $error("overflow left frame open or error uncounted");

endmodule

// ----- dv/tb_crc16_checked_frame_deframer_unit.sv -----
module tb_crc16_checked_frame_deframer_unit;
    import cfd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       pinned;
        t_result    want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    cfd_rx_if  rx_if ();
    cfd_cfg_if cfg_if ();
    cfd_res_if res_if ();

    crc16_checked_frame_deframer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // deframer state as the testbench tracks it
    logic        model_open;
    logic [7:0]  model_prev;
    logic [7:0]  model_count;
    logic [7:0]  model_limit;
    logic [15:0] model_crc;
    logic [15:0] model_cmd;
    logic [15:0] model_errs;
    logic [7:0]  model_hist [3];

    t_result   pending_results [$];
    t_stim_row directed_rows [$];

    bit calm;
    int mismatch_count;
    int result_count;
    int byte_total;
    int ev_tally [6];

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] v;
        v = acc;
        for (int i = 0; i < 8; i++) begin
            v = (v[0] ^ d[i]) ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic void count_frame_error();
        if (model_errs != ERR_SAT) begin
            model_errs = model_errs + 16'd1;
        end
    endfunction

    function automatic t_result deframe_predict(input logic [7:0] b);
        t_result    r;
        logic [7:0] k;
        r = '0;
        r.frame_event = EV_NONE;
        if (b == HEAD_BYTE && model_prev == HEAD_BYTE) begin
            model_count = 8'd0;
            model_crc = CRC_INIT;
            model_open = 1'b1;
            r.frame_event = EV_START;
        end else if (model_open && b == TAIL_BYTE && model_prev == TAIL_BYTE) begin
            model_open = 1'b0;
            if (model_count < CRC_LAG) begin
                count_frame_error();
                r.frame_event = EV_SHORT;
            end else begin
                r.payload_length = model_count - CRC_LAG;
                r.computed_crc = model_crc;
                if ({model_hist[1], model_hist[2]} == model_crc) begin
                    r.frame_event = EV_GOOD;
                end else begin
                    count_frame_error();
                    r.frame_event = EV_CRC_ERR;
                end
            end
        end else begin
            if (model_open) begin
                k = model_count;
                if (k >= CRC_LAG) begin
                    model_crc = crc_step(model_crc, model_hist[2]);
                end
                model_hist[2] = model_hist[1];
                model_hist[1] = model_hist[0];
                model_hist[0] = b;
                if (k == 8'd0) begin
                    model_cmd[15:8] = b;
                end else if (k == 8'd1) begin
                    model_cmd[7:0] = b;
                end
                r.byte_valid = 1'b1;
                r.byte_value = b;
                r.byte_index = k;
                model_count = k + 8'd1;
                if (model_count >= model_limit) begin
                    model_open = 1'b0;
                    count_frame_error();
                    r.frame_event = EV_OVERFLOW;
                end
            end
            model_prev = b;
        end
        r.command_word = model_cmd;
        r.error_total = model_errs;
        return r;
    endfunction

    function automatic t_result result_of(input logic v, input logic [7:0] val,
                                          input logic [7:0] idx, input t_frame_event ev,
                                          input logic [7:0] plen, input logic [15:0] cmd,
                                          input logic [15:0] crc, input logic [15:0] err);
        t_result r;
        r.byte_valid = v;
        r.byte_value = val;
        r.byte_index = idx;
        r.frame_event = ev;
        r.payload_length = plen;
        r.command_word = cmd;
        r.computed_crc = crc;
        r.error_total = err;
        return r;
    endfunction

    function automatic void add_row(input logic [7:0] data, input logic pinned,
                                    input t_result want);
        t_stim_row row;
        row.data = data;
        row.pinned = pinned;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // random body byte that never forms a head or tail pair with the previous one
    function automatic logic [7:0] body_byte(input logic [7:0] prev);
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 9) < 2) begin
            b = $urandom_range(0, 1) ? HEAD_BYTE : TAIL_BYTE;
        end
        if (b == prev && (b == HEAD_BYTE || b == TAIL_BYTE)) begin
            b = b ^ 8'h01;
        end
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic pinned, input t_result want);
        t_result guess;
        int      gap;
        if (!calm && $urandom_range(0, 99) < 25) begin
            gap = pick_gap();
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        guess = deframe_predict(b);
        pending_results.push_back(pinned ? want : guess);
        ev_tally[guess.frame_event]++;
        byte_total++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        send_byte(b, 1'b0, '0);
    endtask

    task automatic drain_results();
        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.max_stored_bytes <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        model_limit = v;
    endtask

    task automatic send_random_frame();
        int          n;
        int          sel;
        int          mode;
        logic [7:0]  b;
        logic [7:0]  last;
        logic [15:0] crc;
        calm = ($urandom_range(0, 99) < 20);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        end
        sel = $urandom_range(0, 99);
        if (sel < 90) begin
            n = $urandom_range(0, 10);
        end else if (sel < 97) begin
            n = $urandom_range(11, 40);
        end else begin
            n = $urandom_range(41, 255);
        end
        mode = $urandom_range(0, 99);
        push_byte(HEAD_BYTE);
        push_byte(HEAD_BYTE);
        last = HEAD_BYTE;
        if (mode >= 84 && mode < 92) begin
            // cut off before the crc
            repeat ($urandom_range(0, 2)) begin
                b = body_byte(last);
                push_byte(b);
                last = b;
            end
            if (last == TAIL_BYTE) begin
                push_byte(8'h00);
            end
            push_byte(TAIL_BYTE);
            push_byte(TAIL_BYTE);
            return;
        end
        if (mode >= 92) begin
            // junk, then a fresh head pair restarts the frame
            repeat ($urandom_range(1, 5)) begin
                b = body_byte(last);
                push_byte(b);
                last = b;
            end
            push_byte(HEAD_BYTE);
            push_byte(HEAD_BYTE);
            last = HEAD_BYTE;
        end
        crc = CRC_INIT;
        for (int i = 0; i < n; i++) begin
            b = body_byte(last);
            crc = crc_step(crc, b);
            push_byte(b);
            last = b;
        end
        if (mode >= 72 && mode < 84) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);
        push_byte(TAIL_BYTE);
        push_byte(TAIL_BYTE);
    endtask

    task automatic random_phase(input int budget);
        int target;
        target = byte_total + budget;
        while (byte_total < target) send_random_frame();
        calm = 1'b0;
    endtask

    // result side stalls
    initial begin
        int hold_left;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                hold_left = pick_gap() - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen.byte_valid = res_if.byte_valid;
            seen.byte_value = res_if.byte_value;
            seen.byte_index = res_if.byte_index;
            seen.frame_event = res_if.frame_event;
            seen.payload_length = res_if.payload_length;
            seen.command_word = res_if.command_word;
            seen.computed_crc = res_if.computed_crc;
            seen.error_total = res_if.error_total;
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result %0d arrived with nothing expected", result_count);
                end
            end else begin
                want = pending_results.pop_front();
                if (seen.byte_valid !== want.byte_valid
                        || seen.byte_value !== want.byte_value
                        || seen.byte_index !== want.byte_index
                        || seen.frame_event !== want.frame_event
                        || seen.payload_length !== want.payload_length
                        || seen.command_word !== want.command_word
                        || seen.computed_crc !== want.computed_crc
                        || seen.error_total !== want.error_total) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d expected: vld=%0d val=%02h idx=%0d ev=%0d len=%0d",
                                 result_count, want.byte_valid, want.byte_value,
                                 want.byte_index, want.frame_event, want.payload_length);
                        $display("    cmd=%04h crc=%04h errs=%0d", want.command_word,
                                 want.computed_crc, want.error_total);
                        $display("  actual: vld=%0d val=%02h idx=%0d ev=%0d len=%0d",
                                 seen.byte_valid, seen.byte_value, seen.byte_index,
                                 seen.frame_event, seen.payload_length);
                        $display("    cmd=%04h crc=%04h errs=%0d", seen.command_word,
                                 seen.computed_crc, seen.error_total);
                    end
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int waited;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'h00;
        cfg_if.valid = 1'b0;
        cfg_if.max_stored_bytes = 8'h00;
        i_rst_n = 1'b0;
        calm = 1'b0;
        mismatch_count = 0;
        result_count = 0;
        byte_total = 0;
        foreach (ev_tally[i]) ev_tally[i] = 0;
        model_open = 1'b0;
        model_prev = 8'h00;
        model_count = 8'h00;
        model_limit = MAX_STORED_RESET;
        model_crc = CRC_INIT;
        model_cmd = 16'h0000;
        model_errs = 16'h0000;
        foreach (model_hist[i]) model_hist[i] = 8'h00;

        // bytes outside a frame, tail pair with no frame open
        add_row(8'h00, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_NONE, 8'd0,
                                       16'h0000, 16'h0000, 16'd0));
        add_row(8'hFF, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_NONE, 8'd0,
                                       16'h0000, 16'h0000, 16'd0));
        add_row(8'h55, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_NONE, 8'd0,
                                       16'h0000, 16'h0000, 16'd0));
        add_row(8'h55, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_NONE, 8'd0,
                                       16'h0000, 16'h0000, 16'd0));
        add_row(8'hAA, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_NONE, 8'd0,
                                       16'h0000, 16'h0000, 16'd0));
        add_row(8'hAA, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_START, 8'd0,
                                       16'h0000, 16'h0000, 16'd0));
        // too short frame
        add_row(8'h55, 1'b1, result_of(1'b1, 8'h55, 8'd0, EV_NONE, 8'd0,
                                       16'h5500, 16'h0000, 16'd0));
        add_row(8'h55, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_SHORT, 8'd0,
                                       16'h5500, 16'h0000, 16'd1));
        // empty payload with a good crc
        add_row(8'hAA, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_NONE, 8'd0,
                                       16'h5500, 16'h0000, 16'd1));
        add_row(8'hAA, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_START, 8'd0,
                                       16'h5500, 16'h0000, 16'd1));
        add_row(8'hFF, 1'b1, result_of(1'b1, 8'hFF, 8'd0, EV_NONE, 8'd0,
                                       16'hFF00, 16'h0000, 16'd1));
        add_row(8'hFF, 1'b1, result_of(1'b1, 8'hFF, 8'd1, EV_NONE, 8'd0,
                                       16'hFFFF, 16'h0000, 16'd1));
        add_row(8'h55, 1'b1, result_of(1'b1, 8'h55, 8'd2, EV_NONE, 8'd0,
                                       16'hFFFF, 16'h0000, 16'd1));
        add_row(8'h55, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_GOOD, 8'd0,
                                       16'hFFFF, 16'hFFFF, 16'd1));
        // empty payload with a bad crc
        add_row(8'hAA, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_NONE, 8'd0,
                                       16'hFFFF, 16'h0000, 16'd1));
        add_row(8'hAA, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_START, 8'd0,
                                       16'hFFFF, 16'h0000, 16'd1));
        add_row(8'h12, 1'b1, result_of(1'b1, 8'h12, 8'd0, EV_NONE, 8'd0,
                                       16'h12FF, 16'h0000, 16'd1));
        add_row(8'hFE, 1'b1, result_of(1'b1, 8'hFE, 8'd1, EV_NONE, 8'd0,
                                       16'h12FE, 16'h0000, 16'd1));
        add_row(8'h55, 1'b1, result_of(1'b1, 8'h55, 8'd2, EV_NONE, 8'd0,
                                       16'h12FE, 16'h0000, 16'd1));
        add_row(8'h55, 1'b1, result_of(1'b0, 8'h00, 8'd0, EV_CRC_ERR, 8'd0,
                                       16'h12FE, 16'hFFFF, 16'd2));
        // restart inside an open frame, then a third head byte
        add_row(8'hAA, 1'b0, '0);
        add_row(8'hAA, 1'b0, '0);
        add_row(8'h01, 1'b0, '0);
        add_row(8'hAA, 1'b0, '0);
        add_row(8'hAA, 1'b0, '0);
        add_row(8'hAA, 1'b0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].data, directed_rows[i].pinned, directed_rows[i].want);
        end

        random_phase(175);
        drain_results();
        random_phase(175);
        set_limit(8'd4);
        random_phase(150);
        set_limit(8'd255);
        random_phase(200);
        set_limit(8'd3);
        random_phase(60);
        set_limit(8'd1);
        random_phase(40);

        // limit of zero: every stored byte overflows
        set_limit(8'd0);
        repeat (8) begin
            push_byte(HEAD_BYTE);
            push_byte(HEAD_BYTE);
            push_byte(8'($urandom_range(0, 127)));
        end

        rx_if.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatch_count += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("sent %0d bytes: %0d frame starts, %0d good, %0d crc errors,",
                 byte_total, ev_tally[EV_START], ev_tally[EV_GOOD], ev_tally[EV_CRC_ERR]);
        $display("    %0d short, %0d overflow", ev_tally[EV_SHORT], ev_tally[EV_OVERFLOW]);
        $display("byte limits 100, 4, 255, 3, 1 and 0 used; error count ended at %0d", model_errs);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
